/* rtl/core/mpic_pkg.sv */
`timescale 1ns / 1ps
package mpic_pkg;

  localparam int SUM_WIDTH = 48;
  localparam int LOG_ITERS = 24;

  localparam int OUT_SUM_W = 48;
  localparam int PR_W      = 32 + SUM_WIDTH;
  localparam int MH_W      = SUM_WIDTH - 32;
  localparam int LN2_W     = 26;
  localparam logic [LN2_W-1:0] LN2_Q26 = 26'd46516320;
  localparam int LG_W      = 5 + LOG_ITERS;
  localparam int LP_W      = LG_W + LN2_W;
  localparam int LN_SH     = LOG_ITERS + 2;
  localparam int RM_W      = LP_W + 1 - LN_SH;
  localparam int SQ_W      = 2 * RM_W - 24;
  localparam int VS_W      = 18 + SQ_W;
  localparam int DIV_STEPS = 32;
  localparam int CNT_W     = 6;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_START_PRICE  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_DEPTH        = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_IMPACT_GAIN  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_DECAY_WEIGHT = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_MAX_CHANGE   = 3'd4;

  localparam logic [31:0] START_PRICE_RST  = 32'd6553600;
  localparam logic [31:0] DEPTH_RST        = 32'd65536;
  localparam logic [31:0] IMPACT_GAIN_RST  = 32'd65536;
  localparam logic [15:0] DECAY_WEIGHT_RST = 16'd61604;
  localparam logic [31:0] MAX_CHANGE_RST   = 32'd655360;

  localparam logic [1:0] HALT_NONE   = 2'd0;
  localparam logic [1:0] HALT_STOP   = 2'd1;
  localparam logic [1:0] HALT_RESUME = 2'd2;

  typedef struct packed {
    logic disp;
    logic mlo;
    logic mhi;
    logic cmp;
    logic div;
    logic price;
    logic linit;
    logic lnorm;
    logic lsq;
    logic lnr;
    logic lrnd;
    logic vsq;
    logic vmul;
    logic vadd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic wend;
    logic halted;
    logic sat;
    logic norm_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/market_price_impact_clearing.sv */
`timescale 1ns / 1ps
// A word without window_end goes from dispatch straight to the output register.
// A window_end word runs 32 restoring-divide steps for the price move (skipped
// on saturation or halt), up to 31 normalize shifts and LOG_ITERS log squarings.
// Throughput: one word at a time; the next is taken once the result is registered.
// Reset (rst_ni low, async) restores default registers, price to start_price default.
module market_price_impact_clearing import mpic_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // [31:0] demand
  input  logic               s_axis_tlast,  // window_end
  input  logic [1:0]         s_axis_tuser,  // [1:0] halt_cmd
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [31:0] cur_price, [63:32] log_ret, [95:64] variance, [143:96] window_demand,
  // [191:144] window_volume, [223:192] steps, [224] is_halted, [225] did_clear
  output logic [231:0]       m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [CFG_AW-1:0]  cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i
);

  cmd_t        cmd;
  sts_t        sts;
  logic        idle, acc;
  logic [31:0] cur_price, log_ret, variance, steps;
  logic [OUT_SUM_W-1:0] wdem, wvol;
  logic        is_halted, did_clear;

  assign s_axis_tready = idle;
  assign acc = s_axis_tvalid && idle;

  mpic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (acc),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .idle_o      (idle)
  );

  mpic_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_accept_i     (acc),
    .demand_i        (s_axis_tdata),
    .window_end_i    (s_axis_tlast),
    .halt_cmd_i      (s_axis_tuser),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .cur_price_o     (cur_price),
    .log_ret_o       (log_ret),
    .variance_o      (variance),
    .window_demand_o (wdem),
    .window_volume_o (wvol),
    .steps_o         (steps),
    .is_halted_o     (is_halted),
    .did_clear_o     (did_clear)
  );

  assign m_axis_tdata = {6'd0, did_clear, is_halted, steps, wvol, wdem,
                         variance, log_ret, cur_price};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word accepted while previous one in flight");

  a_clear_not_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && did_clear |-> !is_halted)
    else $error("clearing reported while halted");

  a_price_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && did_clear |-> cur_price != 32'd0)
    else $error("cleared price below one LSB");

endmodule

/* rtl/core/mpic_ctrl.sv */
`timescale 1ns / 1ps
module mpic_ctrl import mpic_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_accept_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic idle_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MLO   = 4'd2;
  localparam logic [3:0] S_MHI   = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_PRICE = 4'd6;
  localparam logic [3:0] S_LINIT = 4'd7;
  localparam logic [3:0] S_LNORM = 4'd8;
  localparam logic [3:0] S_LSQ   = 4'd9;
  localparam logic [3:0] S_LNR   = 4'd10;
  localparam logic [3:0] S_LRND  = 4'd11;
  localparam logic [3:0] S_VSQ   = 4'd12;
  localparam logic [3:0] S_VMUL  = 4'd13;
  localparam logic [3:0] S_VADD  = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept_i) state_d = S_DISP;
      end
      S_DISP: begin
        cmd_o.disp = 1'b1;
        cnt_d      = '0;
        if (!sts_i.wend) state_d = S_OUT;
        else if (sts_i.halted) state_d = S_LINIT;
        else state_d = S_MLO;
      end
      S_MLO: begin
        cmd_o.mlo = 1'b1;
        state_d   = S_MHI;
      end
      S_MHI: begin
        cmd_o.mhi = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.sat ? S_PRICE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_PRICE;
      end
      S_PRICE: begin
        cmd_o.price = 1'b1;
        state_d     = S_LINIT;
      end
      S_LINIT: begin
        cmd_o.linit = 1'b1;
        state_d     = S_LNORM;
      end
      S_LNORM: begin
        cmd_o.lnorm = 1'b1;
        cnt_d       = '0;
        if (sts_i.norm_done) state_d = S_LSQ;
      end
      S_LSQ: begin
        cmd_o.lsq = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LOG_ITERS - 1)) state_d = S_LNR;
      end
      S_LNR: begin
        cmd_o.lnr = 1'b1;
        state_d   = S_LRND;
      end
      S_LRND: begin
        cmd_o.lrnd = 1'b1;
        state_d    = S_VSQ;
      end
      S_VSQ: begin
        cmd_o.vsq = 1'b1;
        state_d   = S_VMUL;
      end
      S_VMUL: begin
        cmd_o.vmul = 1'b1;
        state_d    = S_VADD;
      end
      S_VADD: begin
        cmd_o.vadd = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        cmd_o.out_load = 1'b1;
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

/* rtl/core/mpic_dp.sv */
`timescale 1ns / 1ps
module mpic_dp import mpic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_AW-1:0]    cfg_addr_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_accept_i,
  input  logic [31:0]          demand_i,
  input  logic                 window_end_i,
  input  logic [1:0]           halt_cmd_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [31:0]          cur_price_o,
  output logic [31:0]          log_ret_o,
  output logic [31:0]          variance_o,
  output logic [OUT_SUM_W-1:0] window_demand_o,
  output logic [OUT_SUM_W-1:0] window_volume_o,
  output logic [31:0]          steps_o,
  output logic                 is_halted_o,
  output logic                 did_clear_o
);

  // configuration; start_price only matters at reset, which uses its reset value
  logic [31:0] depth_q, gain_q, maxc_q;
  logic [15:0] dw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_RST;
      gain_q  <= IMPACT_GAIN_RST;
      dw_q    <= DECAY_WEIGHT_RST;
      maxc_q  <= MAX_CHANGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DEPTH:        depth_q <= cfg_wdata_i;
        CFG_IMPACT_GAIN:  gain_q  <= cfg_wdata_i;
        CFG_DECAY_WEIGHT: dw_q    <= cfg_wdata_i[15:0];
        CFG_MAX_CHANGE:   maxc_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [31:0] dep;
  assign dep = (depth_q == 32'd0) ? 32'd1 : depth_q;

  // market state
  logic [31:0]          price_q, prev_q, var_q, steps_q;
  logic [SUM_WIDTH-1:0] ds_q, vs_q;
  logic                 halt_q, wend_q, clear_q, mv_q;
  logic signed [31:0]   r_q;

  // item accumulation
  logic [SUM_WIDTH:0]   ds_ext, vs_ext;
  logic [SUM_WIDTH-1:0] ds_d, vs_d;
  logic [31:0]          dabs;

  always_comb begin
    dabs   = demand_i[31] ? (~demand_i + 32'd1) : demand_i;
    ds_ext = {ds_q[SUM_WIDTH-1], ds_q}
           + {{(SUM_WIDTH - 31){demand_i[31]}}, demand_i};
    if (ds_ext[SUM_WIDTH] != ds_ext[SUM_WIDTH-1])
      ds_d = ds_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                               : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    else
      ds_d = ds_ext[SUM_WIDTH-1:0];
    vs_ext = {1'b0, vs_q} + (SUM_WIDTH + 1)'(dabs);
    vs_d   = vs_ext[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : vs_ext[SUM_WIDTH-1:0];
  end

  // price impact
  logic                 ds_neg;
  logic [SUM_WIDTH-1:0] dmag;
  logic [MH_W-1:0]      mag_hi;
  logic [SUM_WIDTH-1:0] phi;
  logic [63:0]          plo_q, capm_q;
  logic [PR_W-1:0]      prod_q;
  logic [64:0]          cap_q;
  logic [31:0]          rem_q, dvd_q, q_q;
  logic [32:0]          trial, psum;
  logic                 qbit;

  assign ds_neg = ds_q[SUM_WIDTH-1];
  assign dmag   = ds_neg ? (~ds_q + 1'b1) : ds_q;
  assign mag_hi = dmag[SUM_WIDTH-1:32];
  assign phi    = gain_q * mag_hi;
  assign trial  = {rem_q, dvd_q[31]};
  assign qbit   = (trial >= {1'b0, dep});
  assign psum   = {1'b0, price_q} + {1'b0, q_q};

  // log lanes: a = price, b = prev price
  logic [31:0]          ma_q, mb_q;
  logic [4:0]           na_q, nb_q;
  logic [LOG_ITERS-1:0] fa_q, fb_q;
  logic                 zero_q, lneg_q;
  logic [63:0]          sqa, sqb;
  logic                 a_nrm, b_nrm;
  logic [LG_W-1:0]      la, lb, lmag;
  logic [LP_W-1:0]      lnp_q;
  logic [LP_W:0]        lrnd;
  logic [RM_W-1:0]      rmag, rmag_q;
  logic [2*RM_W-1:0]    rsq;
  logic [SQ_W-1:0]      sq_q;
  logic [47:0]          pa_q;
  logic [16+SQ_W:0]     pb_q;
  logic [16:0]          wc;
  logic [VS_W-1:0]      vsum;

  assign a_nrm = ma_q[31] || (na_q == 5'd0);
  assign b_nrm = mb_q[31] || (nb_q == 5'd0);
  assign sqa   = ma_q * ma_q;
  assign sqb   = mb_q * mb_q;
  assign la    = {na_q, fa_q};
  assign lb    = {nb_q, fb_q};
  assign lmag  = (la < lb) ? (lb - la) : (la - lb);
  assign lrnd  = {1'b0, lnp_q} + ((LP_W + 1)'(1) << (LN_SH - 1));
  assign rmag  = lrnd[LP_W:LN_SH];
  assign rsq   = rmag_q * rmag_q;
  assign wc    = 17'h10000 - {1'b0, dw_q};
  assign vsum  = VS_W'(pa_q) + VS_W'(pb_q);

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.mlo) begin
      plo_q  <= gain_q * dmag[31:0];
      capm_q <= maxc_q * dep;
    end
    if (cmd_i.mhi) begin
      prod_q <= PR_W'(plo_q) + (PR_W'(phi) << 32);
      cap_q  <= {1'b0, capm_q} + 65'(dep);
    end
    if (cmd_i.cmp) begin
      rem_q <= prod_q[63:32];
      dvd_q <= prod_q[31:0];
      q_q   <= sts_o.sat ? maxc_q : 32'd0;
    end
    if (cmd_i.div) begin
      rem_q <= qbit ? 32'(trial - {1'b0, dep}) : trial[31:0];
      dvd_q <= {dvd_q[30:0], 1'b0};
      q_q   <= {q_q[30:0], qbit};
    end
    if (cmd_i.linit) begin
      ma_q   <= price_q;
      mb_q   <= prev_q;
      na_q   <= 5'd31;
      nb_q   <= 5'd31;
      fa_q   <= '0;
      fb_q   <= '0;
      zero_q <= (price_q == 32'd0) || (prev_q == 32'd0);
    end
    if (cmd_i.lnorm) begin
      if (!a_nrm) begin
        ma_q <= {ma_q[30:0], 1'b0};
        na_q <= na_q - 5'd1;
      end
      if (!b_nrm) begin
        mb_q <= {mb_q[30:0], 1'b0};
        nb_q <= nb_q - 5'd1;
      end
    end
    if (cmd_i.lsq) begin
      // square, renormalize to [1,2) and shift out one fraction bit
      ma_q <= sqa[63] ? sqa[63:32] : sqa[62:31];
      fa_q <= {fa_q[LOG_ITERS-2:0], sqa[63]};
      mb_q <= sqb[63] ? sqb[63:32] : sqb[62:31];
      fb_q <= {fb_q[LOG_ITERS-2:0], sqb[63]};
    end
    if (cmd_i.lnr) begin
      lnp_q  <= lmag * LN2_Q26;
      lneg_q <= (la < lb);
    end
    if (cmd_i.lrnd) begin
      rmag_q <= zero_q ? '0 : rmag;
    end
    if (cmd_i.vsq) sq_q <= rsq[2*RM_W-1:24];
    if (cmd_i.vmul) begin
      pa_q <= dw_q * var_q;
      pb_q <= wc * sq_q;
    end
  end

  // r_q is written twice per clearing: zeroed at dispatch, set after rounding
  always_ff @(posedge clk_i) begin
    if (cmd_i.disp) r_q <= '0;
    else if (cmd_i.lrnd)
      r_q <= zero_q ? 32'sd0
           : (lneg_q ? -$signed(32'(rmag)) : $signed(32'(rmag)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_q <= START_PRICE_RST;
      prev_q  <= START_PRICE_RST;
      var_q   <= '0;
      steps_q <= '0;
      ds_q    <= '0;
      vs_q    <= '0;
      halt_q  <= 1'b0;
      wend_q  <= 1'b0;
      clear_q <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      if (in_accept_i) begin
        if (halt_cmd_i == HALT_STOP) halt_q <= 1'b1;
        else if (halt_cmd_i == HALT_RESUME) halt_q <= 1'b0;
        ds_q   <= ds_d;
        vs_q   <= vs_d;
        wend_q <= window_end_i;
      end
      if (cmd_i.disp) clear_q <= 1'b0;
      if (cmd_i.price) begin
        prev_q  <= price_q;
        steps_q <= steps_q + 32'd1;
        clear_q <= 1'b1;
        if (ds_neg) price_q <= (q_q >= price_q) ? 32'd1 : (price_q - q_q);
        else price_q <= psum[32] ? 32'hFFFF_FFFF : psum[31:0];
      end
      if (cmd_i.vadd)
        var_q <= (|vsum[VS_W-1:48]) ? 32'hFFFF_FFFF : vsum[47:16];
      if (cmd_i.out_load && sts_o.out_free) begin
        mv_q <= 1'b1;
        if (wend_q) begin
          ds_q <= '0;
          vs_q <= '0;
        end
      end else if (mv_q && out_ready_i) begin
        mv_q <= 1'b0;
      end
    end
  end

  // result word register
  logic signed [SUM_WIDTH-1:0] ds_s;
  assign ds_s = ds_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load && sts_o.out_free) begin
      cur_price_o     <= price_q;
      log_ret_o       <= r_q;
      variance_o      <= var_q;
      window_demand_o <= OUT_SUM_W'(ds_s);
      window_volume_o <= OUT_SUM_W'(vs_q);
      steps_o         <= steps_q;
      is_halted_o     <= halt_q;
      did_clear_o     <= clear_q;
    end
  end

  assign out_valid_o     = mv_q;
  assign sts_o.wend      = wend_q;
  assign sts_o.halted    = halt_q;
  assign sts_o.sat       = (prod_q >= PR_W'(cap_q));
  assign sts_o.norm_done = a_nrm && b_nrm;
  assign sts_o.out_free  = !mv_q || out_ready_i;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import mpic_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic [31:0] price;
    logic [31:0] lret;
    logic [31:0] var_q;
    logic [47:0] wdem;
    logic [47:0] wvol;
    logic [31:0] steps;
    logic        halted;
    logic        cleared;
  } clear_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic [1:0] s_axis_tuser = HALT_NONE;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [231:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = CFG_START_PRICE;
  logic [31:0] cfg_wdata_i = '0;

  market_price_impact_clearing u_dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state and register copies
  logic [63:0] mk_depth = DEPTH_RST, mk_gain = IMPACT_GAIN_RST;
  logic [63:0] mk_decay = DECAY_WEIGHT_RST, mk_maxchg = MAX_CHANGE_RST;
  logic [63:0] mk_price = START_PRICE_RST, mk_prev = START_PRICE_RST;
  logic [63:0] mk_var = '0, mk_vol = '0, mk_steps = '0;
  longint mk_dsum = 0;
  logic mk_halt = 1'b0;

  clear_res_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0, stall_pct = 0, hold_cnt = 0;

  function automatic logic [63:0] log2_q32(logic [63:0] x);
    int n;
    logic [63:0] m, frac;
    n = 31;
    frac = '0;
    while (n > 0 && x[n] == 1'b0) n--;
    m = x << (31 - n);
    for (int i = 0; i < LOG_ITERS; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(n) << 32) | (frac << (32 - LOG_ITERS));
  endfunction

  function automatic longint ln_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] la, lb, mag, r;
    if (a == 0 || b == 0) return 0;
    la = log2_q32(a);
    lb = log2_q32(b);
    mag = (la < lb) ? lb - la : la - lb;
    r = (mag * 64'(LN2_Q26) + (64'd1 << 33)) >> 34;
    return (la < lb) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void move_price();
    logic [63:0] mag, dep, cap, q;
    logic [127:0] prod;
    longint p;
    mag = (mk_dsum < 0) ? 64'(-mk_dsum) : 64'(mk_dsum);
    dep = (mk_depth != 0) ? mk_depth : 64'd1;
    prod = 128'(mk_gain) * 128'(mag);
    cap = (mk_maxchg + 1) * dep;
    q = (prod[127:64] != 0 || prod[63:0] >= cap) ? mk_maxchg : prod[63:0] / dep;
    mk_prev = mk_price;
    p = longint'(mk_price) + ((mk_dsum < 0) ? -longint'(q) : longint'(q));
    if (p > longint'(64'hFFFF_FFFF)) p = longint'(64'hFFFF_FFFF);
    if (p < 1) p = 1;
    mk_price = 64'(p);
    mk_steps = (mk_steps + 1) & 64'hFFFF_FFFF;
  endfunction

  function automatic clear_res_t predict_clearing(logic [31:0] dem, logic wend, logic [1:0] cmd);
    longint smax, smin, d, r;
    logic [63:0] vmax, a, mag, sq, nv;
    clear_res_t res;
    smax = (longint'(1) << (SUM_WIDTH - 1)) - 1;
    smin = -smax - 1;
    vmax = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SUM_WIDTH);
    d = longint'($signed(dem));
    a = (d < 0) ? 64'(-d) : 64'(d);
    r = 0;
    res.cleared = 1'b0;
    if (cmd == HALT_STOP) mk_halt = 1'b1;
    else if (cmd == HALT_RESUME) mk_halt = 1'b0;
    if (d > 0 && mk_dsum > smax - d) mk_dsum = smax;
    else if (d < 0 && mk_dsum < smin - d) mk_dsum = smin;
    else mk_dsum += d;
    mk_vol = (mk_vol > vmax - a) ? vmax : mk_vol + a;
    res.wdem = mk_dsum[47:0];
    res.wvol = mk_vol[47:0];
    if (wend) begin
      if (!mk_halt) begin
        move_price();
        res.cleared = 1'b1;
      end
      r = ln_ratio(mk_price, mk_prev);
      mag = (r < 0) ? 64'(-r) : 64'(r);
      sq = (mag * mag) >> 24;
      nv = (mk_decay * mk_var + (64'd65536 - mk_decay) * sq) >> 16;
      mk_var = (nv > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nv;
      mk_dsum = 0;
      mk_vol = '0;
    end
    res.price = mk_price[31:0];
    res.lret = r[31:0];
    res.var_q = mk_var[31:0];
    res.steps = mk_steps[31:0];
    res.halted = mk_halt;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h", what, got, want);
  endtask

  task automatic chk_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    clear_res_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected word", 64'(m_axis_tdata[31:0]), '0);
      end else begin
        w = pending_q.pop_front();
        chk_field("cur_price", m_axis_tdata[31:0], w.price);
        chk_field("log_ret", m_axis_tdata[63:32], w.lret);
        chk_field("variance", m_axis_tdata[95:64], w.var_q);
        chk_field("window_demand", m_axis_tdata[143:96], w.wdem);
        chk_field("window_volume", m_axis_tdata[191:144], w.wvol);
        chk_field("steps", m_axis_tdata[223:192], w.steps);
        chk_field("is_halted", m_axis_tdata[224], w.halted);
        chk_field("did_clear", m_axis_tdata[225], w.cleared);
      end
    end
  end

  // receiver: random stalls plus long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] dem, logic wend, logic [1:0] cmd);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= dem;
    s_axis_tlast <= wend;
    s_axis_tuser <= cmd;
    pending_q.push_back(predict_clearing(dem, wend, cmd));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [31:0] sp, logic [31:0] dep, logic [31:0] gain,
                              logic [15:0] dec, logic [31:0] mc);
    logic [31:0] vals[5];
    logic [CFG_AW-1:0] idx[5];
    wait_idle();
    vals = '{sp, dep, gain, 32'(dec), mc};
    idx = '{CFG_START_PRICE, CFG_DEPTH, CFG_IMPACT_GAIN, CFG_DECAY_WEIGHT, CFG_MAX_CHANGE};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_addr_i <= idx[i];
      cfg_wdata_i <= vals[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    // start_price only takes effect at reset, which is never repeated
    mk_depth = dep;
    mk_gain = gain;
    mk_decay = dec;
    mk_maxchg = mc;
  endtask

  function automatic logic [31:0] rand_demand();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(131072)) - 65536);
      2: return 32'($signed($urandom_range(8388608)) - 4194304);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic test_directed();
    send_word(32'h7FFF_FFFF, 1'b0, HALT_NONE);
    send_word(32'h8000_0000, 1'b0, HALT_NONE);
    send_word(32'h0001_0000, 1'b1, HALT_NONE);
    send_word(32'h0000_0000, 1'b1, HALT_NONE);
    send_word(32'hFFFF_FFFF, 1'b1, HALT_NONE);
    send_word(32'h0005_0000, 1'b0, HALT_STOP);
    send_word(32'h0003_0000, 1'b1, HALT_NONE);  // halted window end
    send_word(32'h0001_0000, 1'b0, 2'd3);       // unknown code ignored
    send_word(32'h0000_0001, 1'b1, HALT_RESUME);
    send_word(32'hFFF0_0000, 1'b1, 2'd3);
    send_word(32'h0002_0000, 1'b1, HALT_NONE);
    // wide-open impact: floor at one LSB, then saturate high
    program_regs(32'd1, 32'd1, 32'hFFFF_FFFF, 16'd0, 32'hFFFF_FFFF);
    send_word(32'h8000_0000, 1'b1, HALT_NONE);
    send_word(32'h8000_0000, 1'b1, HALT_NONE);
    send_word(32'h7FFF_FFFF, 1'b1, HALT_NONE);
    send_word(32'h7FFF_FFFF, 1'b1, HALT_NONE);
    send_word(32'h0000_0001, 1'b1, HALT_NONE);
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 32'd0);
    send_word(32'h1234_5678, 1'b1, HALT_NONE);
    send_word(32'h8765_4321, 1'b1, HALT_NONE);
    program_regs(START_PRICE_RST, 32'd0, IMPACT_GAIN_RST, DECAY_WEIGHT_RST, MAX_CHANGE_RST);
    send_word(32'h0000_8000, 1'b1, HALT_NONE);  // zero depth acts as one
    send_word(32'hFFFF_0000, 1'b1, HALT_NONE);
  endtask

  task automatic test_random(int n_words);
    int sent;
    int run;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(9) == 0) begin
        send_word($urandom(), $urandom_range(1), 2'($urandom_range(3)));
        sent++;
      end else begin
        run = $urandom_range(7);
        for (int i = 0; i < run; i++) begin
          send_word(rand_demand(), 1'b0, ($urandom_range(15) == 0) ? 2'($urandom_range(3))
                                                                    : HALT_NONE);
          sent++;
        end
        send_word(rand_demand(), 1'b1, ($urandom_range(5) == 0) ? 2'($urandom_range(2, 1))
                                                                : HALT_NONE);
        sent++;
      end
    end
  endtask

  task automatic test_idling();
    int idle_mode[4] = '{0, 87, 0, 33};
    int stall_mode[4] = '{0, 0, 87, 33};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_regs(START_PRICE_RST, DEPTH_RST, IMPACT_GAIN_RST, DECAY_WEIGHT_RST,
                        MAX_CHANGE_RST);
        1: program_regs($urandom(), 32'd1, 32'd300, 16'd0, 32'hFFFF_FFFF);
        2: program_regs($urandom(), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'h0002_0000);
        default: program_regs($urandom(), $urandom_range(32'hFFFF_FFFF, 1), $urandom(),
                              16'($urandom()), $urandom());
      endcase
      idle_pct = idle_mode[ph];
      stall_pct = stall_mode[ph];
      test_random(210);
    end
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    program_regs(START_PRICE_RST, DEPTH_RST, IMPACT_GAIN_RST, DECAY_WEIGHT_RST, MAX_CHANGE_RST);
    hold_cnt = 400;
    test_random(40);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_idling();
    test_backpressure();
    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/mpic_pkg.sv
rtl/core/mpic_ctrl.sv
rtl/core/mpic_dp.sv
rtl/core/market_price_impact_clearing.sv
tb/sv/tb_top.sv
